// File: rtl/inverse_palette_quantizer_defines.svh
// Assertion macros for the checker file.
`ifndef INVERSE_PALETTE_QUANTIZER_DEFINES_SVH
`define INVERSE_PALETTE_QUANTIZER_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define IPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define IPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/ipq_pkg.sv
package ipq_pkg;

    localparam int CH_W        = 8;
    localparam int SQ_W        = 2 * CH_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int STORE_DEPTH = 255;
    localparam int PAL_W       = 3 * CH_W;

    localparam int OPAQUE_ENTRIES_DEF    = 255;
    localparam int KEPT_CHANNEL_BITS_DEF = 5;

    localparam logic [CH_W-1:0] TRANSPARENT_INDEX = 8'd255;
    localparam logic [CH_W-1:0] FULL_ALPHA        = 8'd255;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    // Pixel channel scaled to 0..255: floor value and "not exact" flag.
    typedef struct packed {
        logic [CH_W-1:0] fl;
        logic            inexact;
    } t_scaled;

    // Data marching down the distance chain, one palette entry per slot.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [CH_W-1:0]  idx;
        logic [SUM_W-1:0] sum;
        logic [CH_W-1:0]  pal_red;
        logic [CH_W-1:0]  pal_green;
        logic [CH_W-1:0]  pal_blue;
    } t_cell_bus;

endpackage

// File: rtl/ipq_in_if.sv
interface ipq_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, op, entry_index, red, green, blue, alpha, input ready);
    modport sink   (input valid, op, entry_index, red, green, blue, alpha, output ready);
endinterface

// File: rtl/ipq_out_if.sv
interface ipq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] color_index;

    modport source (output valid, color_index, input ready);
    modport sink   (input valid, color_index, output ready);
endinterface

// File: rtl/ipq_cfg_if.sv
interface ipq_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/ipq_ram.sv
module ipq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 255
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ipq_cell.sv
module ipq_cell #(
    parameter ipq_pkg::t_chan CHANNEL = ipq_pkg::CH_RED
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipq_pkg::t_scaled   i_scaled,
    input  ipq_pkg::t_cell_bus i_bus,
    output ipq_pkg::t_cell_bus o_bus
);
    import ipq_pkg::*;

    logic [CH_W-1:0]  w_p;
    logic [CH_W:0]    w_ceil;
    logic [CH_W-1:0]  w_mag;
    logic [SQ_W-1:0]  w_sq;
    t_cell_bus        n_bus;
    t_cell_bus        r_bus;

    always_comb begin
        case (CHANNEL)
            CH_RED:   w_p = i_bus.pal_red;
            CH_GREEN: w_p = i_bus.pal_green;
            default:  w_p = i_bus.pal_blue;
        endcase
    end

    // Truncation toward zero: floor above the palette value, ceiling below it.
    assign w_ceil = {1'b0, i_scaled.fl} + {{CH_W{1'b0}}, i_scaled.inexact};
    assign w_mag  = (i_scaled.fl >= w_p) ? (i_scaled.fl - w_p)
                                          : CH_W'({1'b0, w_p} - w_ceil);
    assign w_sq   = w_mag * w_mag;

    always_comb begin
        n_bus     = i_bus;
        n_bus.sum = i_bus.sum + SUM_W'(w_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= n_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bus.last      <= n_bus.last;
        r_bus.idx       <= n_bus.idx;
        r_bus.sum       <= n_bus.sum;
        r_bus.pal_red   <= n_bus.pal_red;
        r_bus.pal_green <= n_bus.pal_green;
        r_bus.pal_blue  <= n_bus.pal_blue;
    end

    assign o_bus = r_bus;

endmodule

// File: rtl/inverse_palette_quantizer.sv
// Load item: one per cycle while the block is idle.
// Pixel item: the palette RAM read port scans one entry per cycle, the sums pass the red,
// green and blue cells, and the best index is registered as the result; no new item is
// accepted until the result is registered and the block is back in idle.
// Transparent pixel (alpha keyed, alpha not full): skips the scan. A stalled result holds the next one.
// Reset is synchronous, active low: clears control and alpha_keyed; palette is unknown.
module inverse_palette_quantizer #(
    parameter int OPAQUE_ENTRIES    = ipq_pkg::OPAQUE_ENTRIES_DEF,
    parameter int KEPT_CHANNEL_BITS = ipq_pkg::KEPT_CHANNEL_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ipq_in_if.sink    i_pix,
    ipq_cfg_if.sink   i_cfg,
    ipq_out_if.source o_res
);
    import ipq_pkg::*;

    localparam int CodeMax = (1 << KEPT_CHANNEL_BITS) - 1;
    localparam int AddrW   = $clog2(STORE_DEPTH);
    localparam logic [AddrW-1:0] LastEntry = AddrW'(OPAQUE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PUSH
    } t_state;

    t_state            r_state;
    logic [AddrW-1:0]  r_addr;
    logic              r_alpha_keyed;
    logic              r_out_valid;
    logic [CH_W-1:0]   r_color;
    logic [CH_W-1:0]   r_best_idx;
    logic [SUM_W-1:0]  r_best_dist;

    logic              r_rd_valid;
    logic              r_rd_last;
    logic [AddrW-1:0]  r_rd_idx;

    logic [CH_W-1:0]   w_fl_tbl      [CodeMax+1];
    logic              w_inexact_tbl [CodeMax+1];
    t_scaled           n_scaled [3];
    t_scaled           r_scaled [3];

    logic              w_pix_hs;
    logic              w_we;
    logic              w_re;
    logic [PAL_W-1:0]  w_rdata;
    t_cell_bus         w_bus [4];
    logic              w_upd;

    // Code-to-0..255 scaling table, built at elaboration.
    for (genvar gi = 0; gi <= CodeMax; gi++) begin : g_scale
        assign w_fl_tbl[gi]      = CH_W'((gi * 255) / CodeMax);
        assign w_inexact_tbl[gi] = (((gi * 255) % CodeMax) != 0);
    end

    assign w_pix_hs    = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_scaled[0].fl      = w_fl_tbl[i_pix.red[7 -: KEPT_CHANNEL_BITS]];
        n_scaled[0].inexact = w_inexact_tbl[i_pix.red[7 -: KEPT_CHANNEL_BITS]];
        n_scaled[1].fl      = w_fl_tbl[i_pix.green[7 -: KEPT_CHANNEL_BITS]];
        n_scaled[1].inexact = w_inexact_tbl[i_pix.green[7 -: KEPT_CHANNEL_BITS]];
        n_scaled[2].fl      = w_fl_tbl[i_pix.blue[7 -: KEPT_CHANNEL_BITS]];
        n_scaled[2].inexact = w_inexact_tbl[i_pix.blue[7 -: KEPT_CHANNEL_BITS]];
    end

    always_ff @(posedge i_clk) begin
        if (w_pix_hs && i_pix.op == OP_PIXEL) begin
            r_scaled <= n_scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_keyed <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_alpha_keyed <= i_cfg.data;
        end
    end

    // Palette store; loads beyond the store are dropped.
    assign w_we = w_pix_hs && (i_pix.op == OP_LOAD)
                  && (i_pix.entry_index < CH_W'(STORE_DEPTH));
    assign w_re = (r_state == ST_SCAN);

    ipq_ram #(
        .WIDTH (PAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_pix.entry_index[AddrW-1:0]),
        .i_wdata ({i_pix.red, i_pix.green, i_pix.blue}),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= (r_addr == LastEntry);
        r_rd_idx  <= r_addr;
    end

    always_comb begin
        w_bus[0].valid     = r_rd_valid;
        w_bus[0].last      = r_rd_last;
        w_bus[0].idx       = CH_W'(r_rd_idx);
        w_bus[0].sum       = '0;
        w_bus[0].pal_red   = w_rdata[PAL_W-1 -: CH_W];
        w_bus[0].pal_green = w_rdata[CH_W +: CH_W];
        w_bus[0].pal_blue  = w_rdata[CH_W-1:0];
    end

    ipq_cell #(.CHANNEL(CH_RED)) u_cell_red (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scaled (r_scaled[0]),
        .i_bus    (w_bus[0]),
        .o_bus    (w_bus[1])
    );

    ipq_cell #(.CHANNEL(CH_GREEN)) u_cell_green (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scaled (r_scaled[1]),
        .i_bus    (w_bus[1]),
        .o_bus    (w_bus[2])
    );

    ipq_cell #(.CHANNEL(CH_BLUE)) u_cell_blue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scaled (r_scaled[2]),
        .i_bus    (w_bus[2]),
        .o_bus    (w_bus[3])
    );

    // Strict compare keeps the lowest index on a tie.
    assign w_upd = w_bus[3].valid
                   && (w_bus[3].idx == '0 || w_bus[3].sum < r_best_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_PUSH && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_upd) begin
                r_best_idx  <= w_bus[3].idx;
                r_best_dist <= w_bus[3].sum;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_pix_hs && i_pix.op == OP_PIXEL) begin
                        if (r_alpha_keyed && i_pix.alpha != FULL_ALPHA) begin
                            r_best_idx <= TRANSPARENT_INDEX;
                            r_state    <= ST_PUSH;
                        end else begin
                            r_addr  <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LastEntry) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_bus[3].valid && w_bus[3].last) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_color <= r_best_idx;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.color_index = r_color;

endmodule

// File: rtl/ipq_checker.sv
`include "inverse_palette_quantizer_defines.svh"

module ipq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pix_valid,
    input logic       i_pix_ready,
    input logic       i_pix_op,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [7:0] i_res_color_index
);
    import ipq_pkg::*;

    logic w_pix_acc;

    assign w_pix_acc = i_pix_valid && i_pix_ready;

    // A pixel transaction always blocks the input in the cycle after it is accepted.
    `IPQ_ASSERT_NEXT(a_pixel_blocks, w_pix_acc && i_pix_op == OP_PIXEL, !i_pix_ready, "pixel transaction did not block input")
    // Palette loads never stall the input side.
    `IPQ_ASSERT_NEXT(a_load_flows, w_pix_acc && i_pix_op == OP_LOAD, i_pix_ready, "palette load stalled input")
    // A new result appears only as the block returns to idle.
    `IPQ_ASSERT_SAME(a_result_idle, $rose(i_res_valid), i_pix_ready, "result issued while busy")
    `IPQ_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_color_index), "stalled result changed")

endmodule

bind inverse_palette_quantizer ipq_checker u_ipq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_pix_valid       (i_pix.valid),
    .i_pix_ready       (i_pix.ready),
    .i_pix_op          (i_pix.op),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_color_index (o_res.color_index)
);

// File: tb/sv/inverse_palette_quantizer_tb.sv
module inverse_palette_quantizer_tb;
    import ipq_pkg::*;

    localparam int CODE_MAX       = (1 << KEPT_CHANNEL_BITS_DEF) - 1;
    localparam int DROPPED_BITS   = CH_W - KEPT_CHANNEL_BITS_DEF;
    localparam int SETTLE_CYCLES  = OPAQUE_ENTRIES_DEF + 45;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 370;

    logic i_clk;
    logic i_rst_n;

    ipq_in_if  pix_if ();
    ipq_cfg_if cfg_if ();
    ipq_out_if res_if ();

    inverse_palette_quantizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Local copy of the palette and the mode register
    logic [PAL_W-1:0] palette_model [STORE_DEPTH];
    logic             alpha_keyed_model;
    logic [CH_W-1:0]  index_queue [$];
    logic [CH_W-1:0]  popped_index;

    int mismatches     = 0;
    int burst_left;
    int stalled_cycles = 0;
    int rx_period      = 1;
    int rx_open        = 1;
    int rx_count       = 0;
    int rx_left        = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int scaled_diff(input logic [CH_W-1:0] chan, input logic [CH_W-1:0] pal);
        int code;
        int num;
        code = int'(chan >> DROPPED_BITS);
        num  = code * 255 - int'(pal) * CODE_MAX;
        return num / CODE_MAX;
    endfunction

    function automatic logic [CH_W-1:0] nearest_color(input logic [CH_W-1:0] r,
                                                      input logic [CH_W-1:0] g,
                                                      input logic [CH_W-1:0] b);
        logic [CH_W-1:0] best;
        int best_dist;
        int dr, dg, db, sq_dist;
        best      = '0;
        best_dist = 32'h7fff_ffff;
        for (int i = 0; i < OPAQUE_ENTRIES_DEF && i < STORE_DEPTH; i++) begin
            dr      = scaled_diff(r, palette_model[i][23:16]);
            dg      = scaled_diff(g, palette_model[i][15:8]);
            db      = scaled_diff(b, palette_model[i][7:0]);
            sq_dist = dr * dr + dg * dg + db * db;
            // strict compare: lowest index keeps a tie
            if (sq_dist < best_dist) begin
                best_dist = sq_dist;
                best      = CH_W'(i);
            end
        end
        return best;
    endfunction

    task automatic note_mismatch(input string what, input logic [CH_W-1:0] exp_idx,
                                 input logic [CH_W-1:0] act_idx);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected color_index %0d, got %0d", what, exp_idx, act_idx);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (index_queue.size() == 0) begin
                note_mismatch("unexpected result", '0, res_if.color_index);
            end else begin
                popped_index = index_queue.pop_front();
                if (res_if.color_index !== popped_index)
                    note_mismatch("color_index", popped_index, res_if.color_index);
            end
        end
    end

    // Receiver stall pattern: open/closed windows of random period
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_period = $urandom_range(1, 12);
            rx_open   = ($urandom_range(0, 3) == 0) ? rx_period : $urandom_range(1, rx_period);
            rx_left   = rx_period * $urandom_range(2, 8);
            rx_count  = 0;
        end
        res_if.ready = (rx_count < rx_open);
        rx_count     = (rx_count + 1) % rx_period;
        rx_left--;
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [CH_W-1:0] idx,
                             input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
        @(negedge i_clk);
        if (burst_left == 0) begin
            pix_if.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pix_if.valid       = 1'b1;
        pix_if.op          = op;
        pix_if.entry_index = idx;
        pix_if.red         = r;
        pix_if.green       = g;
        pix_if.blue        = b;
        pix_if.alpha       = a;
        do @(posedge i_clk); while (!pix_if.ready);
        if (op == OP_PIXEL) begin
            if (alpha_keyed_model && a != FULL_ALPHA)
                index_queue.push_back(TRANSPARENT_INDEX);
            else
                index_queue.push_back(nearest_color(r, g, b));
        end else if (idx < STORE_DEPTH) begin
            palette_model[idx] = {r, g, b};
        end
    endtask

    // Drop valid, drain results, then let any load still in flight finish
    task automatic settle_block();
        @(negedge i_clk);
        pix_if.valid = 1'b0;
        while (index_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_alpha_keyed(input logic value);
        settle_block();
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        alpha_keyed_model = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_pixel_color(input logic [PAL_W-1:0] col, input logic [CH_W-1:0] a);
        send_item(OP_PIXEL, CH_W'($urandom_range(0, 255)), col[23:16], col[15:8], col[7:0], a);
    endtask

    task automatic test_palette_load();
        logic [PAL_W-1:0] col;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            col = PAL_W'($urandom);
            case (i)
                0:       col = 24'h000000;
                1:       col = 24'hff0000;
                2:       col = 24'h00ff00;
                3:       col = 24'h0000ff;
                200:     col = palette_model[100];  // duplicate for a tie
                254:     col = 24'hffffff;
                default: ;
            endcase
            send_item(OP_LOAD, CH_W'(i), col[23:16], col[15:8], col[7:0], 8'h00);
        end
        // entry 255 lies outside the store
        send_item(OP_LOAD, 8'd255, 8'h12, 8'h34, 8'h56, 8'hff);
    endtask

    task automatic test_directed_pixels();
        send_item(OP_PIXEL, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_PIXEL, 8'd255, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(OP_PIXEL, 8'd0,   8'h07, 8'h07, 8'h07, 8'h00);
        send_item(OP_PIXEL, 8'd0,   8'hf8, 8'hf8, 8'hf8, 8'h80);
        send_item(OP_PIXEL, 8'd0,   8'hff, 8'h00, 8'h00, 8'h00);
        send_item(OP_PIXEL, 8'd0,   8'h00, 8'hff, 8'h00, 8'h00);
        send_item(OP_PIXEL, 8'd0,   8'h00, 8'h00, 8'hff, 8'h00);
        send_pixel_color(palette_model[100], 8'h00);
        send_pixel_color(palette_model[200], 8'hff);
    endtask

    task automatic test_alpha_keyed();
        write_alpha_keyed(1'b1);
        send_item(OP_PIXEL, 8'd0, 8'hff, 8'hff, 8'hff, FULL_ALPHA);
        send_item(OP_PIXEL, 8'd0, 8'hff, 8'hff, 8'hff, 8'h00);
        send_item(OP_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'hfe);
        send_item(OP_PIXEL, 8'd0, 8'h40, 8'h80, 8'hc0, 8'h7f);
        send_item(OP_LOAD,  8'd5, 8'h81, 8'h82, 8'h83, 8'h00);
        send_item(OP_LOAD,  8'd255, 8'hff, 8'hff, 8'hff, 8'h00);
        send_item(OP_PIXEL, 8'd0, 8'h81, 8'h82, 8'h83, FULL_ALPHA);
        send_item(OP_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, FULL_ALPHA);
        write_alpha_keyed(1'b0);
        send_item(OP_PIXEL, 8'd0, 8'h81, 8'h82, 8'h83, 8'h01);
    endtask

    task automatic send_random_item();
        logic [PAL_W-1:0] col;
        logic [CH_W-1:0]  a;
        a = ($urandom_range(0, 1) == 1) ? FULL_ALPHA : CH_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 2) == 0)
                col = palette_model[$urandom_range(0, STORE_DEPTH - 1)];
            else
                col = PAL_W'($urandom);
            send_item(OP_LOAD, CH_W'($urandom_range(0, 255)), col[23:16], col[15:8], col[7:0], a);
        end else begin
            case ($urandom_range(0, 3))
                0:       col = palette_model[$urandom_range(0, STORE_DEPTH - 1)];
                1:       col = palette_model[$urandom_range(0, STORE_DEPTH - 1)]
                               ^ PAL_W'($urandom & 32'h0f0f0f);
                default: col = PAL_W'($urandom);
            endcase
            send_pixel_color(col, a);
        end
    endtask

    task automatic test_random_traffic(input logic keyed);
        write_alpha_keyed(keyed);
        repeat (PHASE_ITEMS) send_random_item();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.op          = OP_LOAD;
        pix_if.entry_index = '0;
        pix_if.red         = '0;
        pix_if.green       = '0;
        pix_if.blue        = '0;
        pix_if.alpha       = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = 1'b0;
        alpha_keyed_model  = 1'b0;
        burst_left         = 0;
        foreach (palette_model[i]) palette_model[i] = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_palette_load();
        test_directed_pixels();
        test_alpha_keyed();
        test_random_traffic(1'b0);
        test_random_traffic(1'b1);
        test_random_traffic(1'b0);
        test_random_traffic(1'b1);

        settle_block();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/ipq_pkg.sv
rtl/ipq_in_if.sv
rtl/ipq_out_if.sv
rtl/ipq_cfg_if.sv
rtl/ipq_ram.sv
rtl/ipq_cell.sv
rtl/inverse_palette_quantizer.sv
rtl/ipq_checker.sv
tb/sv/inverse_palette_quantizer_tb.sv
